/* rtl/pnp_pkg.sv */
// ============================================================================
// pnp_pkg
// Shared types, character codes and the digit decoder for the prefixed
// number parser.
// ============================================================================
`default_nettype none

package pnp_pkg;

    // Token position
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PENDX  = 3'd3,
        PH_DIGITS = 3'd4
    } phase_t;

    // Decoded digit: ok is low for a character that is no digit at all
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } digit_t;

    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_LO_A   = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_X   = 8'h78;  // 'x'
    localparam logic [7:0] CH_LO_Z   = 8'h7A;  // 'z'
    localparam logic [7:0] CH_UP_A   = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_X   = 8'h58;  // 'X'
    localparam logic [7:0] CH_UP_Z   = 8'h5A;  // 'Z'

    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_BIN  = 6'd2;
    localparam logic [5:0] LETTER_OFS = 6'd10;

    // Map a case-insensitive ASCII digit to its value
    function automatic digit_t pnp_digit(input logic [7:0] c);
        digit_t r;
        logic [7:0] diff;
        r    = '0;
        diff = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff  = c - CH_ZERO;
            r.ok  = 1'b1;
            r.val = diff[5:0];
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            diff  = c - CH_LO_A;
            r.ok  = 1'b1;
            r.val = diff[5:0] + LETTER_OFS;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            diff  = c - CH_UP_A;
            r.ok  = 1'b1;
            r.val = diff[5:0] + LETTER_OFS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/prefixed_number_parser_core.sv */
// ============================================================================
// prefixed_number_parser_core
// Streams the characters of a token and returns its signed numeric value.
// ============================================================================
// Characters arrive one per transaction with tlast on the final character of
// a token. An optional '-' or '+' sign and an optional base prefix ('$' hex,
// '#' decimal, '%' binary, or 0x / 0X hex when a character follows it) are
// recognised; otherwise the base sampled from default_base at the first
// character applies. The block accepts one character every cycle but for the
// stall below: each character is registered in the input register, then folded
// into the accumulator by a single 64 x 6 multiply-add, and a token's result
// enters the output register, with m_tvalid high, as its last character leaves
// the input register. The accumulator is kept already sign-applied, so no
// negation follows the multiply-add. Results wait in an output register while
// the next token keeps streaming in; only the final character of the next token
// holds in the input register, stalling the input, until that result has left.
`default_nettype none

module prefixed_number_parser_core
    import pnp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wr_en,
    input  wire logic [5:0]         cfg_wr_data,   // default_base

    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [7:0]         s_tdata,       // [7:0] ch
    input  wire logic               s_tlast,       // is_last

    output      logic               m_tvalid,
    input  wire logic               m_tready,
    output      logic signed [63:0] m_tdata,       // [63:0] value
    output      logic [0:0]         m_tuser        // [0] valid_res
);

    // Registers
    logic [5:0]   default_base_reg;
    logic         in_valid_reg;
    logic [7:0]   in_ch_reg;
    logic         in_last_reg;

    phase_t       phase_reg,  phase_next;
    logic         neg_reg,    neg_next;
    logic [5:0]   base_reg,   base_next;
    logic [63:0]  acc_reg,    acc_next;
    logic         failed_reg, failed_next;

    logic         m_valid_reg;
    logic [63:0]  m_data_reg;
    logic         m_user_reg;

    logic         s_fire;
    logic         st_fire;
    logic         res_load;

    // Datapath
    digit_t       dig;
    logic         do_prefix;
    logic         add_en;
    logic         use_acc;
    logic [63:0]  mul_a;
    logic [63:0]  prod;
    logic [63:0]  sdig;
    logic [63:0]  sum;
    logic         res_ok;
    logic [63:0]  res_value;

    // Handshake: the character stage advances unless it holds a final
    // character and the output register is still full
    assign st_fire  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || st_fire;
    assign s_fire   = s_tvalid && s_tready;
    assign res_load = st_fire && in_last_reg;

    // Hold the configured base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_base_reg <= BASE_DEC;
        end else if (cfg_wr_en) begin
            default_base_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (st_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Next token state for the character in the input register
    always_comb begin
        dig         = pnp_digit(in_ch_reg);
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        failed_next = failed_reg;
        do_prefix   = 1'b0;
        add_en      = 1'b0;
        use_acc     = 1'b0;

        case (phase_reg)
            PH_START: begin
                base_next = default_base_reg;
                if (!in_last_reg && (in_ch_reg == CH_MINUS || in_ch_reg == CH_PLUS)) begin
                    neg_next   = (in_ch_reg == CH_MINUS);
                    phase_next = PH_SIGN;
                end else begin
                    do_prefix = 1'b1;
                end
            end
            PH_SIGN: begin
                do_prefix = 1'b1;
            end
            PH_ZERO: begin
                if ((in_ch_reg == CH_LO_X || in_ch_reg == CH_UP_X) && !in_last_reg) begin
                    phase_next = PH_PENDX;
                end else begin
                    // the held zero is a digit of its own, rejected only in base 0
                    if (base_reg == 6'd0) begin
                        failed_next = 1'b1;
                    end
                    add_en     = 1'b1;
                    phase_next = PH_DIGITS;
                end
            end
            PH_PENDX: begin
                base_next  = BASE_HEX;
                add_en     = 1'b1;
                phase_next = PH_DIGITS;
            end
            default: begin
                if (!failed_reg) begin
                    add_en  = 1'b1;
                    use_acc = 1'b1;
                end
            end
        endcase

        // Base prefix, leading zero or first digit
        if (do_prefix) begin
            if (in_ch_reg == CH_DOLLAR || in_ch_reg == CH_HASH || in_ch_reg == CH_PCT) begin
                if (in_ch_reg == CH_DOLLAR) begin
                    base_next = BASE_HEX;
                end else if (in_ch_reg == CH_HASH) begin
                    base_next = BASE_DEC;
                end else begin
                    base_next = BASE_BIN;
                end
                if (in_last_reg) begin
                    failed_next = 1'b1;
                end
                phase_next = PH_DIGITS;
            end else if (in_ch_reg == CH_ZERO && !in_last_reg) begin
                phase_next = PH_ZERO;
            end else begin
                add_en     = 1'b1;
                phase_next = PH_DIGITS;
            end
        end

        // Sign-applied multiply-add: acc * base +/- digit
        mul_a = use_acc ? acc_reg : 64'd0;
        prod  = mul_a * {58'd0, base_next};
        sdig  = neg_reg ? (64'd0 - {58'd0, dig.val}) : {58'd0, dig.val};
        sum   = prod + sdig;

        if (add_en) begin
            if (!dig.ok || dig.val >= base_next) begin
                failed_next = 1'b1;
            end else begin
                acc_next = sum;
            end
        end

        res_ok    = !failed_next;
        res_value = failed_next ? 64'd0 : acc_next;

        // Drop the token state once its result is formed
        if (in_last_reg) begin
            phase_next  = PH_START;
            neg_next    = 1'b0;
            base_next   = default_base_reg;
            acc_next    = 64'd0;
            failed_next = 1'b0;
        end
    end

    // Token state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            base_reg   <= BASE_DEC;
            acc_reg    <= 64'd0;
            failed_reg <= 1'b0;
        end else if (st_fire) begin
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            base_reg   <= base_next;
            acc_reg    <= acc_next;
            failed_reg <= failed_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res_value;
            m_user_reg <= res_ok;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // Checks
    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 64'd0))
        else $error("invalid result carries a non-zero value");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (phase_reg == PH_START && !failed_reg && acc_reg == 64'd0))
        else $error("token state not cleared after a result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && in_last_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full output register");

    a_prefix_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SIGN || phase_reg == PH_ZERO || phase_reg == PH_PENDX)
            |-> (!failed_reg && acc_reg == 64'd0))
        else $error("prefix phase with accumulated state");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for prefixed_number_parser_core. Streams tokens of
// characters through the slave channel, predicts each signed value and its
// validity flag, and compares every result transaction in order. A short
// run of directed tokens goes first. Random tokens follow under a series of
// default bases, with random idling on both channels for all but the last.
// ============================================================================

module tb;
    import pnp_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 6;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 136;
    localparam int N_PHASES        = 9;
    localparam int MAX_REPORTS     = 40;

    // Predicts the result of each token and keeps the numbers still owed
    class parse_scoreboard;
        typedef struct {
            bit          ok;
            logic [63:0] value;
        } number_t;

        number_t     expected_numbers[$];
        logic [5:0]  dflt_base;
        logic [5:0]  tok_base;
        phase_t      pos;
        bit          neg;
        bit          bad;
        logic [63:0] acc;
        int          errors;
        int          checked;
        int          n_valid;

        function new();
            dflt_base = BASE_DEC;
            errors    = 0;
            checked   = 0;
            n_valid   = 0;
            clear();
        endfunction

        function void clear();
            pos      = PH_START;
            neg      = 1'b0;
            tok_base = dflt_base;
            acc      = '0;
            bad      = 1'b0;
        endfunction

        function void set_base(logic [5:0] b);
            dflt_base = b;
        endfunction

        function int pending();
            return expected_numbers.size();
        endfunction

        // Fold one digit character into the running value
        function void fold_digit(logic [7:0] c);
            int d;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
                d = c - CH_LO_A + LETTER_OFS;
            end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
                d = c - CH_UP_A + LETTER_OFS;
            end else begin
                d = -1;
            end
            if (d < 0 || d >= tok_base) begin
                bad = 1'b1;
            end else begin
                acc = acc * tok_base + d;
            end
        endfunction

        // First character after the optional sign: a base prefix or a digit
        function void take_prefix(logic [7:0] c, bit last);
            if (c == CH_DOLLAR || c == CH_HASH || c == CH_PCT) begin
                tok_base = (c == CH_DOLLAR) ? BASE_HEX : (c == CH_HASH) ? BASE_DEC : BASE_BIN;
                if (last) bad = 1'b1;
                pos = PH_DIGITS;
            end else if (c == CH_ZERO && !last) begin
                pos = PH_ZERO;
            end else begin
                fold_digit(c);
                pos = PH_DIGITS;
            end
        endfunction

        // Advance the prediction by one accepted character
        function void note_char(logic [7:0] c, bit last);
            number_t n;
            case (pos)
                PH_START: begin
                    tok_base = dflt_base;
                    if (!last && (c == CH_MINUS || c == CH_PLUS)) begin
                        neg = (c == CH_MINUS);
                        pos = PH_SIGN;
                    end else begin
                        take_prefix(c, last);
                    end
                end
                PH_SIGN: begin
                    take_prefix(c, last);
                end
                PH_ZERO: begin
                    if ((c == CH_LO_X || c == CH_UP_X) && !last) begin
                        pos = PH_PENDX;
                    end else begin
                        fold_digit(CH_ZERO);
                        fold_digit(c);
                        pos = PH_DIGITS;
                    end
                end
                PH_PENDX: begin
                    tok_base = BASE_HEX;
                    acc      = '0;
                    fold_digit(c);
                    pos      = PH_DIGITS;
                end
                default: begin
                    if (!bad) fold_digit(c);
                end
            endcase
            if (last) begin
                n.ok    = !bad;
                n.value = bad ? 64'd0 : (neg ? -acc : acc);
                expected_numbers.push_back(n);
                clear();
            end
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        // Compare one result transaction with the oldest expected number
        function void check_result(bit ok, logic [63:0] value);
            number_t n;
            checked++;
            if (expected_numbers.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none expected, actual valid_res=%0b value=%h",
                             $time, ok, value);
                return;
            end
            n = expected_numbers.pop_front();
            if (n.ok) n_valid++;
            if (ok !== n.ok) report("valid_res", 64'(n.ok), 64'(ok));
            if (value !== n.value) report("value", n.value, value);
        endfunction
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [5:0]         cfg_wr_data = BASE_DEC;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata     = 8'h00;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic signed [63:0] m_tdata;
    logic [0:0]         m_tuser;

    parse_scoreboard sb;
    logic [7:0]      tok_q[$];
    logic [5:0]      cur_base     = BASE_DEC;
    bit              src_idle_on  = 1'b1;
    bit              sink_idle_on = 1'b1;
    int              n_tokens     = 0;
    int              n_chars      = 0;
    int              quiet_cycles = 0;

    string directed_words[10] = '{"-", "$", "+%", "0x", "-0XfF", "#9", "%12", "0", "09", "+$1"};

    prefixed_number_parser_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Pick a digit character for base b, now and then one out of range
    function automatic logic [7:0] digit_char(logic [5:0] b);
        int d;
        if (b < BASE_BIN || b > 6'd36 || $urandom_range(0, 24) == 0) begin
            d = $urandom_range(0, 35);
        end else begin
            d = $urandom_range(0, b - 1);
        end
        if (d < LETTER_OFS) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(d - LETTER_OFS);
    endfunction

    // Offer one character and hold it until the transaction completes
    task automatic push_char(input logic [7:0] c, input bit last);
        if (src_idle_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_char(c, last);
        n_chars++;
    endtask

    task automatic send_token();
        for (int i = 0; i < tok_q.size(); i++) push_char(tok_q[i], i == tok_q.size() - 1);
        n_tokens++;
    endtask

    // Result side: random bursts of back-pressure, none once switched off
    initial begin
        int span;
        @(posedge aclk);
        forever begin
            if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 15);
            end else begin
                m_tready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            repeat (span) @(posedge aclk);
        end
    end

    // Check each result transaction; end the run if traffic stops
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [5:0] phase_bases[N_PHASES];
        logic [5:0] tok_b;
        int         sent;
        int         n_digits;
        bit         long_run;

        sb = new();
        phase_bases = '{BASE_HEX, BASE_BIN, 6'd36, 6'd0, 6'd63, 6'd1,
                        6'($urandom_range(2, 36)), 6'($urandom_range(37, 62)), BASE_DEC};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed tokens under the reset base
        foreach (directed_words[w]) begin
            tok_q.delete();
            for (int i = 0; i < directed_words[w].len(); i++) tok_q.push_back(directed_words[w][i]);
            send_token();
        end
        tok_q = '{8'h37, 8'h00};
        send_token();
        tok_q = '{8'hFF};
        send_token();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES - 1) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end

            // Let the block drain, then change the default base
            s_tvalid <= 1'b0;
            while (sb.pending() != 0) @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_bases[p];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            sb.set_base(phase_bases[p]);
            cur_base = phase_bases[p];

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                tok_q.delete();
                if ($urandom_range(0, 7) == 0) begin
                    // Noise: stray bytes, often the special characters
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 15))
                            0:       tok_q.push_back(CH_MINUS);
                            1:       tok_q.push_back(CH_PLUS);
                            2:       tok_q.push_back(CH_DOLLAR);
                            3:       tok_q.push_back(CH_HASH);
                            4:       tok_q.push_back(CH_PCT);
                            5:       tok_q.push_back(CH_ZERO);
                            6:       tok_q.push_back(CH_LO_X);
                            7:       tok_q.push_back(CH_UP_X);
                            default: tok_q.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                end else begin
                    // Well-formed shape: sign, prefix, digits of the right base
                    case ($urandom_range(0, 3))
                        1:       tok_q.push_back(CH_MINUS);
                        2:       tok_q.push_back(CH_PLUS);
                        default: ;
                    endcase
                    tok_b = cur_base;
                    case ($urandom_range(0, 7))
                        0: begin
                            tok_q.push_back(CH_DOLLAR);
                            tok_b = BASE_HEX;
                        end
                        1: begin
                            tok_q.push_back(CH_HASH);
                            tok_b = BASE_DEC;
                        end
                        2: begin
                            tok_q.push_back(CH_PCT);
                            tok_b = BASE_BIN;
                        end
                        3: begin
                            tok_q.push_back(CH_ZERO);
                            tok_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                            tok_b = BASE_HEX;
                        end
                        default: ;
                    endcase
                    long_run = ($urandom_range(0, 9) == 0);
                    if (long_run && tok_b == BASE_BIN) n_digits = $urandom_range(60, 70);
                    else if (long_run) n_digits = $urandom_range(12, 24);
                    else n_digits = $urandom_range(0, 6);
                    repeat (n_digits) tok_q.push_back(digit_char(tok_b));
                    // Break the odd token with a random byte
                    if ($urandom_range(0, 9) == 0)
                        tok_q.insert($urandom_range(0, tok_q.size()), 8'($urandom_range(0, 255)));
                end
                if (tok_q.size() == 0) tok_q.push_back(digit_char(cur_base));
                sent += tok_q.size();
                send_token();
            end
        end

        // Wait for the last results, then idle for DRAIN_CYCLES to catch strays
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d tokens (%0d characters) under %0d default bases.",
                 n_tokens, n_chars, N_PHASES + 1);
        $display("Checked %0d results, %0d of them well formed; %0d mismatches.",
                 sb.checked, sb.n_valid, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/pnp_pkg.sv
rtl/prefixed_number_parser_core.sv
bench/tb.sv
